// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the string parser.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every clock edge outside reset.
`define ULEBSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property with a precondition, written as an overlapping implication.
`define ULEBSP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== sv/ulebsp_pkg.sv =====
// Shared types and codes for the length-prefixed string parser.
// No dependencies.
`timescale 1ns / 1ps

package ulebsp_pkg;

  typedef enum logic [1:0] {
    PH_HINT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NULL   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_ERR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TRUNC    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_NEGATIVE = 2'd3
  } err_t;

  localparam int VALUE_W     = 31;
  localparam int GROUP_SHIFT = 7;

  typedef struct packed {
    logic               vld;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    err_t               code;
    logic               last;
  } res_t;

endpackage

// ===== sv/uleb_prefixed_string_parser.sv =====
// Top level of the length-prefixed string parser: input word register,
// parser core and result register. Depends on ulebsp_pkg, ulebsp_core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   Input channel: one stream byte per word (in_data_byte), or an end-of-stream
//   marker (in_stream_end). Each word gives zero or one result word.
//   Result channel: out_kind (null string, length header, payload byte, error),
//   out_value (length or byte), out_error_code and out_last, which marks the
//   final result of a string.
//   A word is moved when valid is high and stall is low at a rising edge.
//   The input register holds an accepted word until the result register is
//   free; the word then moves through the parser into the result register.
//   Throughput: one word per cycle while out_stall is low; the parser state
//   is updated by one short combinational step between the two registers.
//   When out_stall holds a result, the result register keeps it and the
//   input register can still take one more word; in_stall rises only when
//   both are full.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to waiting for a hint byte with a zero length and zero counters.
module uleb_prefixed_string_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [30:0] out_value,
  output logic [1:0]  out_error_code,
  output logic        out_last
);

  logic             in_vld_r;
  logic [7:0]       in_data_r;
  logic             in_end_r;
  logic             out_vld_r;
  ulebsp_pkg::res_t out_r;
  ulebsp_pkg::res_t res;
  logic             out_free;
  logic             fire;

  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data_byte;
      in_end_r  <= in_stream_end;
    end
  end

  ulebsp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (in_data_r),
    .stream_end (in_end_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_kind       = out_r.kind;
  assign out_value      = out_r.value;
  assign out_error_code = out_r.code;
  assign out_last       = out_r.last;

  `ULEBSP_ASSERT_IMP(a_err_last, out_vld_r && (out_r.kind == ulebsp_pkg::KIND_ERR), out_r.last, "error word without last")
  `ULEBSP_ASSERT_IMP(a_code_kind, out_vld_r, (out_r.kind == ulebsp_pkg::KIND_ERR) == (out_r.code != ulebsp_pkg::ERR_NONE), "error code does not match kind")
  `ULEBSP_ASSERT_IMP(a_null_word, out_vld_r && (out_r.kind == ulebsp_pkg::KIND_NULL), out_r.last && (out_r.value == '0), "null string word malformed")
  `ULEBSP_ASSERT_IMP(a_fire_room, fire, out_free, "input word consumed while result register blocked")

endmodule

// ===== sv/ulebsp_core.sv =====
// Parser state (phase, length accumulator, group and byte counters) and the
// per-word update. Depends on ulebsp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ulebsp_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output ulebsp_pkg::res_t  res
);

  localparam int ACC_W       = LENGTH_BITS;
  localparam int FULL_GROUPS = LENGTH_BITS / 8;
  localparam int FINAL_BITS  = LENGTH_BITS - ulebsp_pkg::GROUP_SHIFT * FULL_GROUPS;
  localparam int FINAL_MASK  = (1 << FINAL_BITS) - 1;
  localparam int GC_W        = $clog2(FULL_GROUPS + 1);
  localparam int EXT_W       = (LENGTH_BITS > ulebsp_pkg::VALUE_W) ?
                               LENGTH_BITS : ulebsp_pkg::VALUE_W;
  localparam int VW          = ulebsp_pkg::VALUE_W;

  ulebsp_pkg::phase_t phase_r, phase_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [GC_W-1:0]    gc_r, gc_nxt;
  logic [VW-1:0]      br_r, br_nxt;

  logic               last_grp;
  logic               final_bad;
  logic               len_done;
  logic [ACC_W-1:0]   len_v;
  logic [EXT_W-1:0]   len_ext;
  logic               len_neg;
  logic               len_zero;

  // length word with the current group merged in
  always_comb begin
    last_grp  = (gc_r >= GC_W'(FULL_GROUPS));
    final_bad = last_grp && (32'(data_byte) > 32'(FINAL_MASK));
    if (last_grp) begin
      len_v = acc_r | (ACC_W'(data_byte) << (ulebsp_pkg::GROUP_SHIFT * FULL_GROUPS));
    end else begin
      len_v = acc_r | (ACC_W'(data_byte[6:0]) << (ulebsp_pkg::GROUP_SHIFT * gc_r));
    end
    len_done = last_grp ? !final_bad : !data_byte[7];
    len_ext  = EXT_W'(len_v);
    len_neg  = len_v[ACC_W-1] || ((len_ext >> VW) != '0);
    len_zero = (len_v == '0);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_r)
        ulebsp_pkg::PH_HINT: begin
          if (!stream_end && (data_byte != 8'd0)) phase_nxt = ulebsp_pkg::PH_LEN;
        end
        ulebsp_pkg::PH_LEN: begin
          if (stream_end || final_bad) begin
            phase_nxt = ulebsp_pkg::PH_HINT;
          end else if (len_done) begin
            phase_nxt = (len_neg || len_zero) ? ulebsp_pkg::PH_HINT : ulebsp_pkg::PH_DATA;
          end
        end
        ulebsp_pkg::PH_DATA: begin
          if (stream_end || (br_r <= VW'(1))) phase_nxt = ulebsp_pkg::PH_HINT;
        end
        default: phase_nxt = ulebsp_pkg::PH_HINT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    acc_nxt    = acc_r;
    gc_nxt     = gc_r;
    br_nxt     = br_r;
    res.vld    = 1'b0;
    res.kind   = ulebsp_pkg::KIND_NULL;
    res.value  = '0;
    res.code   = ulebsp_pkg::ERR_NONE;
    res.last   = 1'b0;
    if (fire) begin
      case (phase_r)
        ulebsp_pkg::PH_LEN: begin
          if (stream_end || final_bad || (len_done && len_neg)) begin
            acc_nxt  = '0;
            gc_nxt   = '0;
            br_nxt   = '0;
            res.vld  = 1'b1;
            res.kind = ulebsp_pkg::KIND_ERR;
            res.last = 1'b1;
            res.code = stream_end ? ulebsp_pkg::ERR_TRUNC :
                       final_bad  ? ulebsp_pkg::ERR_OVERFLOW : ulebsp_pkg::ERR_NEGATIVE;
          end else if (len_done) begin
            acc_nxt   = '0;
            gc_nxt    = '0;
            br_nxt    = len_ext[VW-1:0];
            res.vld   = 1'b1;
            res.kind  = ulebsp_pkg::KIND_HEADER;
            res.value = len_ext[VW-1:0];
            res.last  = len_zero;
          end else begin
            acc_nxt = len_v;
            gc_nxt  = gc_r + GC_W'(1);
          end
        end
        ulebsp_pkg::PH_DATA: begin
          res.vld  = 1'b1;
          res.last = 1'b1;
          if (stream_end) begin
            br_nxt   = '0;
            res.kind = ulebsp_pkg::KIND_ERR;
            res.code = ulebsp_pkg::ERR_TRUNC;
          end else begin
            res.kind  = ulebsp_pkg::KIND_DATA;
            res.value = VW'(data_byte);
            if (br_r <= VW'(1)) begin
              br_nxt = '0;
            end else begin
              br_nxt   = br_r - VW'(1);
              res.last = 1'b0;
            end
          end
        end
        default: begin
          // hint byte: zero is a null string, any other byte opens a length; an end-of-stream marker gives nothing
          acc_nxt = '0;
          gc_nxt  = '0;
          if (!stream_end && (data_byte == 8'd0)) begin
            res.vld  = 1'b1;
            res.kind = ulebsp_pkg::KIND_NULL;
            res.last = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ulebsp_pkg::PH_HINT;
      acc_r   <= '0;
      gc_r    <= '0;
      br_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      gc_r    <= gc_nxt;
      br_r    <= br_nxt;
    end
  end

  `ULEBSP_ASSERT_IMP(a_data_count, phase_r == ulebsp_pkg::PH_DATA, br_r != '0, "payload phase with no bytes left")
  `ULEBSP_ASSERT_IMP(a_hint_clear, phase_r == ulebsp_pkg::PH_HINT, (acc_r == '0) && (gc_r == '0), "length state not cleared while idle")
  `ULEBSP_ASSERT(a_group_range, gc_r <= GC_W'(FULL_GROUPS), "group count past final group")

endmodule

// ===== test/tb_uleb_prefixed_string_parser.sv =====
// Self-checking testbench for uleb_prefixed_string_parser: drives byte words with random
// bursts and stalls, and checks every result word against a scoreboard that predicts it.
// Depends on ulebsp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_uleb_prefixed_string_parser;

  localparam int LENGTH_BITS = 32;
  localparam int FULL_GROUPS = LENGTH_BITS / 8;
  localparam int FINAL_MASK =
    (1 << (LENGTH_BITS - ulebsp_pkg::GROUP_SHIFT * FULL_GROUPS)) - 1;
  localparam int WORD_TARGET = 1850;

  class parse_scoreboard;
    ulebsp_pkg::phase_t phase;
    logic [63:0]        len_acc;
    int unsigned        grp_cnt;
    logic [31:0]        remaining;
    ulebsp_pkg::res_t   expected_q[$];
    int                 errors;
    int                 kind_cnt[4];
    int                 err_cnt[4];

    function new();
      phase = ulebsp_pkg::PH_HINT;
      len_acc = '0;
      grp_cnt = 0;
      remaining = '0;
      errors = 0;
    endfunction

    function bit idle();
      return phase == ulebsp_pkg::PH_HINT;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(ulebsp_pkg::kind_t k, logic [30:0] v, ulebsp_pkg::err_t c, logic l);
      ulebsp_pkg::res_t r;
      r.vld = 1'b1;
      r.kind = k;
      r.value = v;
      r.code = c;
      r.last = l;
      expected_q.push_back(r);
    endfunction

    function void abort(ulebsp_pkg::err_t c);
      phase = ulebsp_pkg::PH_HINT;
      len_acc = '0;
      grp_cnt = 0;
      remaining = '0;
      push(ulebsp_pkg::KIND_ERR, '0, c, 1'b1);
    endfunction

    function void close_length();
      logic [63:0] len;
      len = len_acc;
      len_acc = '0;
      grp_cnt = 0;
      if (len[LENGTH_BITS-1] || len > 64'h7fff_ffff) begin
        abort(ulebsp_pkg::ERR_NEGATIVE);
      end else if (len == 0) begin
        phase = ulebsp_pkg::PH_HINT;
        remaining = '0;
        push(ulebsp_pkg::KIND_HEADER, '0, ulebsp_pkg::ERR_NONE, 1'b1);
      end else begin
        phase = ulebsp_pkg::PH_DATA;
        remaining = len[31:0];
        push(ulebsp_pkg::KIND_HEADER, len[30:0], ulebsp_pkg::ERR_NONE, 1'b0);
      end
    endfunction

    function void note_word(logic [7:0] b, logic eos);
      if (eos) begin
        if (phase != ulebsp_pkg::PH_HINT) abort(ulebsp_pkg::ERR_TRUNC);
        return;
      end
      case (phase)
        ulebsp_pkg::PH_HINT: begin
          if (b == 0) begin
            push(ulebsp_pkg::KIND_NULL, '0, ulebsp_pkg::ERR_NONE, 1'b1);
          end else begin
            phase = ulebsp_pkg::PH_LEN;
            len_acc = '0;
            grp_cnt = 0;
          end
        end
        ulebsp_pkg::PH_LEN: begin
          if (grp_cnt >= FULL_GROUPS) begin
            if (b > FINAL_MASK) begin
              abort(ulebsp_pkg::ERR_OVERFLOW);
            end else begin
              len_acc |= 64'(b) << (ulebsp_pkg::GROUP_SHIFT * FULL_GROUPS);
              close_length();
            end
          end else begin
            len_acc |= 64'(b & 8'h7f) << (ulebsp_pkg::GROUP_SHIFT * grp_cnt);
            if (b <= 8'h7f) close_length();
            else grp_cnt++;
          end
        end
        default: begin
          if (remaining <= 1) begin
            remaining = '0;
            phase = ulebsp_pkg::PH_HINT;
            push(ulebsp_pkg::KIND_DATA, 31'(b), ulebsp_pkg::ERR_NONE, 1'b1);
          end else begin
            remaining--;
            push(ulebsp_pkg::KIND_DATA, 31'(b), ulebsp_pkg::ERR_NONE, 1'b0);
          end
        end
      endcase
    endfunction

    function void check_result(ulebsp_pkg::kind_t k, logic [30:0] v, ulebsp_pkg::err_t c,
                               logic l);
      ulebsp_pkg::res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: kind %0d value %0d code %0d last %0b",
                 $time, k, v, c, l);
        return;
      end
      e = expected_q.pop_front();
      kind_cnt[e.kind]++;
      err_cnt[e.code]++;
      if (k !== e.kind) begin
        errors++;
        $display("%0t: kind mismatch: expected %0d, got %0d", $time, e.kind, k);
      end
      if (v !== e.value) begin
        errors++;
        $display("%0t: value mismatch: expected %0d, got %0d", $time, e.value, v);
      end
      if (c !== e.code) begin
        errors++;
        $display("%0t: error_code mismatch: expected %0d, got %0d", $time, e.code, c);
      end
      if (l !== e.last) begin
        errors++;
        $display("%0t: last mismatch: expected %0b, got %0b", $time, e.last, l);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [30:0] out_value;
  logic [1:0]  out_error_code;
  logic        out_last;

  parse_scoreboard sb = new();
  int burst_left = 0;
  int gap_max = 0;
  int words_sent = 0;

  uleb_prefixed_string_parser #(.LENGTH_BITS(LENGTH_BITS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_stream_end(in_stream_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_value(out_value),
    .out_error_code(out_error_code),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver back-pressure: off, random, or alternating runs; the mode is redrawn at random
  int stall_cyc = 0;
  int stall_mode = 0;
  int stall_run = 0;
  logic stall_hold = 1'b0;
  always @(negedge clk) begin
    stall_cyc++;
    if (stall_cyc % 256 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_run == 0) begin
      stall_hold = ~stall_hold;
      stall_run = $urandom_range(1, 8);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= stall_hold;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(ulebsp_pkg::kind_t'(out_kind), out_value,
                      ulebsp_pkg::err_t'(out_error_code), out_last);
  end

  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) gap_max = $urandom_range(0, 2) * 4;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_stream_end <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    sb.note_word(b, eos);
  endtask

  // base-128 length, optionally padded with redundant continuation groups
  task automatic send_length(input int unsigned len, input int pad);
    int n;
    logic [7:0] b;
    n = 1;
    while (n < 5 && (len >> (ulebsp_pkg::GROUP_SHIFT * n)) != 0) n++;
    n = (n + pad > 5) ? 5 : n + pad;
    for (int i = 0; i < n; i++) begin
      if (i < 4) b = 8'((len >> (ulebsp_pkg::GROUP_SHIFT * i)) & 32'h7f) |
                     ((i < n - 1) ? 8'h80 : 8'h00);
      else b = 8'(len >> 28);
      send_word(b, 1'b0);
    end
  endtask

  task automatic send_string(input logic [7:0] hint, input int unsigned len, input int pad);
    send_word(hint, 1'b0);
    send_length(len, pad);
    repeat (len) send_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_long_prefix(input logic [7:0] final_byte);
    send_word(8'($urandom_range(1, 255)), 1'b0);
    repeat (4) send_word(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
    send_word(final_byte, 1'b0);
  endtask

  initial begin
    int r;
    int len;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_word(8'h00, 1'b0);
    send_word(8'h5c, 1'b1);
    send_string(8'h0b, 0, 0);
    send_string(8'hff, 1, 0);
    send_string(8'h01, 2, 1);
    send_word(8'h0b, 1'b0);
    repeat (4) send_word(8'h80, 1'b0);
    send_word(8'h10, 1'b0);
    send_word(8'h0b, 1'b0);
    repeat (4) send_word(8'hff, 1'b0);
    send_word(8'h0f, 1'b0);
    send_word(8'h0b, 1'b0);
    repeat (4) send_word(8'hff, 1'b0);
    send_word(8'h07, 1'b0);
    send_word(8'h5a, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h0b, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b1);

    // random
    while (words_sent < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(0, 6) : (r < 99) ? $urandom_range(7, 40)
                                                          : $urandom_range(100, 300);
        send_string(($urandom_range(0, 1) != 0) ? 8'h0b : 8'($urandom_range(1, 255)), len,
                    ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4));
      end else if (r < 70) begin
        send_word(8'h00, 1'b0);
      end else if (r < 78) begin
        send_word(8'($urandom_range(1, 255)), 1'b0);
        if ($urandom_range(0, 1) != 0) begin
          repeat ($urandom_range(0, 3)) send_word(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
        end else begin
          len = $urandom_range(1, 10);
          send_length(len, 0);
          repeat ($urandom_range(0, len - 1)) send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 83) begin
        send_long_prefix(8'($urandom_range(16, 255)));
      end else if (r < 88) begin
        send_long_prefix(8'($urandom_range(8, 15)));
      end else if (r < 93) begin
        send_long_prefix(8'($urandom_range(1, 7)));
        repeat ($urandom_range(0, 3)) send_word(8'($urandom_range(0, 255)), 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 97) begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected result words never arrived", $time, sb.pending());
    end

    $display("Run covered %0d input words: %0d null strings, %0d headers, %0d payload bytes.",
             words_sent, sb.kind_cnt[ulebsp_pkg::KIND_NULL],
             sb.kind_cnt[ulebsp_pkg::KIND_HEADER], sb.kind_cnt[ulebsp_pkg::KIND_DATA]);
    $display("Error words: %0d truncated, %0d overflow, %0d negative length.",
             sb.err_cnt[ulebsp_pkg::ERR_TRUNC], sb.err_cnt[ulebsp_pkg::ERR_OVERFLOW],
             sb.err_cnt[ulebsp_pkg::ERR_NEGATIVE]);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
